### rtl/mer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIDI event router with sustain.
// No dependencies.
package mer_pkg;

    localparam int OP_W          = 2;
    localparam int NOTE_W        = 7;
    localparam int AMOUNT_W      = 7;
    localparam int KIND_W        = 2;
    localparam int PARAM_IDX_W   = 4;
    localparam int PARAM_VAL_W   = 8;
    localparam int HALF_SET_W    = 64;
    localparam int CC_LOW_W      = 56;
    localparam int CC_HIGH_W     = 14;
    localparam int BANK_W        = 8;
    localparam int CFG_DATA_W    = 56;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_PARAMS    = 10;
    localparam int BANK_PARAM    = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [NOTE_W-1:0]   SUSTAIN_CC        = 7'd64;
    localparam logic [AMOUNT_W-1:0] SUSTAIN_THRESHOLD = 7'd63;
    localparam logic [8:0]          FULL_SCALE        = 9'd127;
    localparam logic [BANK_W-1:0]   BANK_RESET        = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_CTRL     = 2'd2
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_PARAM   = 2'd2,
        KIND_BITMAP  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CC_LOW  = 2'd0,
        CFG_CC_HIGH = 2'd1,
        CFG_BANKS   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PARAM   = 2'd2,
        CMD_PEDAL   = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                 op;
        logic [NOTE_W-1:0]       note;
        logic [PARAM_IDX_W-1:0]  idx;
        logic [PARAM_VAL_W-1:0]  val;
        logic                    pedal_level;
    } mer_cmd_t;

endpackage

### rtl/mer_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, event classification, bank scaling.
// Depends on mer_pkg.
module mer_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_fire,
    input  logic [mer_pkg::OP_W-1:0]       operation,
    input  logic [mer_pkg::NOTE_W-1:0]     key_or_param,
    input  logic [mer_pkg::AMOUNT_W-1:0]   amount,
    output logic                           push,
    output mer_pkg::mer_cmd_t              cmd
);
    import mer_pkg::*;

    logic [CC_LOW_W-1:0]            cc_low_reg;
    logic [CC_HIGH_W-1:0]           cc_high_reg;
    logic [BANK_W-1:0]              banks_reg;
    logic [CC_LOW_W+CC_HIGH_W-1:0]  cc_all;
    logic                           match;
    logic [PARAM_IDX_W-1:0]         match_idx;
    logic [BANK_W-1:0]              banks_m1;
    logic [BANK_W+AMOUNT_W-1:0]     prod;
    logic [BANK_W:0]                digit_sum;
    logic [BANK_W-1:0]              quot;
    logic [PARAM_VAL_W-1:0]         bank_val;
    logic                           useful;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_low_reg  <= '0;
            cc_high_reg <= '0;
            banks_reg   <= BANK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CC_LOW:  cc_low_reg  <= cfg_wdata[CC_LOW_W-1:0];
                CFG_CC_HIGH: cc_high_reg <= cfg_wdata[CC_HIGH_W-1:0];
                CFG_BANKS:   banks_reg   <= cfg_wdata[BANK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cc_all = {cc_high_reg, cc_low_reg};

    // lowest matching index wins
    always_comb begin
        match     = 1'b0;
        match_idx = '0;
        for (int i = NUM_PARAMS - 1; i >= 0; i--) begin
            if (cc_all[NOTE_W*i +: NOTE_W] == key_or_param) begin
                match     = 1'b1;
                match_idx = PARAM_IDX_W'(i);
            end
        end
    end

    // x / 127 with x = 128a + b: quotient is a plus carries of (a + b) over 127
    assign banks_m1  = (banks_reg == '0) ? '0 : banks_reg - BANK_W'(1);
    assign prod      = banks_m1 * amount;
    assign digit_sum = {1'b0, prod[BANK_W+AMOUNT_W-1:AMOUNT_W]}
                     + {2'b0, prod[AMOUNT_W-1:0]};
    always_comb begin
        quot = prod[BANK_W+AMOUNT_W-1:AMOUNT_W];
        if (digit_sum >= FULL_SCALE)
            quot = quot + BANK_W'(1);
        if (digit_sum >= {FULL_SCALE[7:0], 1'b0})
            quot = quot + BANK_W'(1);
    end
    assign bank_val = quot + PARAM_VAL_W'(1);

    always_comb begin
        cmd             = '0;
        cmd.op          = CMD_PRESS;
        cmd.note        = key_or_param;
        cmd.pedal_level = (amount > SUSTAIN_THRESHOLD);
        useful          = 1'b0;
        unique case (operation)
            OP_NOTE_ON: begin
                useful = 1'b1;
                cmd.op = (amount != '0) ? CMD_PRESS : CMD_RELEASE;
            end
            OP_NOTE_OFF: begin
                useful = 1'b1;
                cmd.op = CMD_RELEASE;
            end
            OP_CTRL: begin
                if (key_or_param == SUSTAIN_CC) begin
                    useful = 1'b1;
                    cmd.op = CMD_PEDAL;
                end else if (match) begin
                    useful  = 1'b1;
                    cmd.op  = CMD_PARAM;
                    cmd.idx = match_idx;
                    cmd.val = (match_idx == PARAM_IDX_W'(BANK_PARAM)) ? bank_val
                                                                      : {1'b0, amount};
                end
            end
            default: ;
        endcase
    end

    assign push = in_fire && useful;

endmodule

### rtl/mer_queue.sv
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on mer_pkg.
module mer_queue #(
    parameter int DEPTH = mer_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mer_pkg::mer_cmd_t push_cmd,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output mer_pkg::mer_cmd_t head
);
    import mer_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mer_cmd_t            mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

### rtl/mer_back.sv
`timescale 1ns / 1ps
// Back end: pedal state, deferred note set, registered result request.
// Depends on mer_pkg.
module mer_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    input  mer_pkg::mer_cmd_t                 cmd,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mer_pkg::KIND_W-1:0]        out_kind,
    output logic [mer_pkg::NOTE_W-1:0]        out_note,
    output logic [mer_pkg::PARAM_IDX_W-1:0]   out_idx,
    output logic [mer_pkg::PARAM_VAL_W-1:0]   out_val,
    output logic [mer_pkg::HALF_SET_W-1:0]    out_low,
    output logic [mer_pkg::HALF_SET_W-1:0]    out_high
);
    import mer_pkg::*;

    logic                      pedal_reg;
    logic [2*HALF_SET_W-1:0]   deferred_reg;
    logic                      valid_reg;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [NOTE_W-1:0]         note_reg, note_next;
    logic [PARAM_IDX_W-1:0]    idx_reg, idx_next;
    logic [PARAM_VAL_W-1:0]    val_reg, val_next;
    logic [2*HALF_SET_W-1:0]   set_reg, set_next;
    logic                      emit;

    assign cmd_pop = cmd_valid && (!valid_reg || out_ready);

    always_comb begin
        unique case (cmd.op)
            CMD_PRESS:   emit = 1'b1;
            CMD_RELEASE: emit = !pedal_reg;
            CMD_PARAM:   emit = 1'b1;
            CMD_PEDAL:   emit = pedal_reg && !cmd.pedal_level;
            default:     emit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pedal_reg    <= 1'b0;
            deferred_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cmd_pop)
                valid_reg <= emit;
            else if (out_ready)
                valid_reg <= 1'b0;
            if (cmd_pop) begin
                if (cmd.op == CMD_RELEASE && pedal_reg)
                    deferred_reg[cmd.note] <= 1'b1;
                if (cmd.op == CMD_PEDAL) begin
                    pedal_reg <= cmd.pedal_level;
                    if (pedal_reg && !cmd.pedal_level)
                        deferred_reg <= '0;
                end
            end
        end
    end

    always_comb begin
        kind_next = '0;
        note_next = '0;
        idx_next  = '0;
        val_next  = '0;
        set_next  = '0;
        unique case (cmd.op)
            CMD_PRESS: begin
                kind_next = KIND_PRESS;
                note_next = cmd.note;
            end
            CMD_RELEASE: begin
                kind_next = KIND_RELEASE;
                note_next = cmd.note;
            end
            CMD_PARAM: begin
                kind_next = KIND_PARAM;
                idx_next  = cmd.idx;
                val_next  = cmd.val;
            end
            CMD_PEDAL: begin
                kind_next = KIND_BITMAP;
                set_next  = deferred_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && emit) begin
            kind_reg <= kind_next;
            note_reg <= note_next;
            idx_reg  <= idx_next;
            val_reg  <= val_next;
            set_reg  <= set_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_note  = note_reg;
    assign out_idx   = idx_reg;
    assign out_val   = val_reg;
    assign out_low   = set_reg[HALF_SET_W-1:0];
    assign out_high  = set_reg[2*HALF_SET_W-1:HALF_SET_W];

endmodule

### rtl/midi_event_router_with_sustain_top.sv
// An accepted event is written to the command queue, then to the result register.
// Throughput: one event per cycle; the result register stalls only on m_ready.
// Unused events never enter the queue; deferred releases pass it but give no result.
// Reset (aresetn low at a clock edge) clears the queue, pedal state, deferred notes,
// and sets controller numbers to 0 and bank count to 1.
`timescale 1ns / 1ps
module midi_event_router_with_sustain_top #(
    parameter int QUEUE_DEPTH = mer_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mer_pkg::OP_W-1:0]          s_operation,
    input  logic [mer_pkg::NOTE_W-1:0]        s_key_or_param,
    input  logic [mer_pkg::AMOUNT_W-1:0]      s_amount,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mer_pkg::KIND_W-1:0]        m_result_kind,
    output logic [mer_pkg::NOTE_W-1:0]        m_note_number,
    output logic [mer_pkg::PARAM_IDX_W-1:0]   m_param_index,
    output logic [mer_pkg::PARAM_VAL_W-1:0]   m_param_value,
    output logic [mer_pkg::HALF_SET_W-1:0]    m_released_low,
    output logic [mer_pkg::HALF_SET_W-1:0]    m_released_high
);
    import mer_pkg::*;

    logic     q_not_full;
    logic     q_not_empty;
    logic     q_push;
    logic     q_pop;
    mer_cmd_t front_cmd;
    mer_cmd_t head_cmd;

    assign s_ready = q_not_full;

    mer_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_fire      (s_valid && q_not_full),
        .operation    (s_operation),
        .key_or_param (s_key_or_param),
        .amount       (s_amount),
        .push         (q_push),
        .cmd          (front_cmd)
    );

    mer_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    mer_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_kind  (m_result_kind),
        .out_note  (m_note_number),
        .out_idx   (m_param_index),
        .out_val   (m_param_value),
        .out_low   (m_released_low),
        .out_high  (m_released_high)
    );

endmodule

### rtl/mer_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the MIDI event router, bound to the top level.
// Depends on mer_pkg and midi_event_router_with_sustain_top.
module mer_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [mer_pkg::KIND_W-1:0]        m_result_kind,
    input logic [mer_pkg::NOTE_W-1:0]        m_note_number,
    input logic [mer_pkg::PARAM_IDX_W-1:0]   m_param_index,
    input logic [mer_pkg::PARAM_VAL_W-1:0]   m_param_value,
    input logic [mer_pkg::HALF_SET_W-1:0]    m_released_low,
    input logic [mer_pkg::HALF_SET_W-1:0]    m_released_high
);
    import mer_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_note_number) && $stable(m_param_value))
        else $error("stalled result request changed");

    a_set_only_bitmap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_BITMAP |->
            m_released_low == '0 && m_released_high == '0)
        else $error("bitmap on non-bitmap request");

    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_PARAM |-> m_param_index < PARAM_IDX_W'(NUM_PARAMS))
        else $error("parameter index out of range");

    a_note_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_PARAM || m_result_kind == KIND_BITMAP) |->
            m_note_number == '0)
        else $error("note number on non-note request");

    a_key_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_PRESS || m_result_kind == KIND_RELEASE) |->
            m_param_index == '0 && m_param_value == '0)
        else $error("parameter fields on key request");

endmodule

bind midi_event_router_with_sustain_top mer_checker u_mer_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_result_kind   (m_result_kind),
    .m_note_number   (m_note_number),
    .m_param_index   (m_param_index),
    .m_param_value   (m_param_value),
    .m_released_low  (m_released_low),
    .m_released_high (m_released_high)
);
